// ===== design/bounded_list_head_tail_insert_delete_macros.svh =====
// Assertion helpers for the checker file.
`ifndef BOUNDED_LIST_HEAD_TAIL_INSERT_DELETE_MACROS_SVH
`define BOUNDED_LIST_HEAD_TAIL_INSERT_DELETE_MACROS_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define BLHT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define BLHT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/blht_pkg.sv =====
package blht_pkg;

  localparam int VALUE_W = 32;
  localparam int MODE_W  = 2;
  localparam int POS_W   = 6;
  localparam int COUNT_W = 6;

  localparam logic [MODE_W-1:0] MODE_FRONT  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_BACK   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DELETE = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SHIFT_RD,
    ST_SHIFT_WR,
    ST_STREAM
  } state_t;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } mem_ctl_t;

endpackage

// ===== design/blht_addr.sv =====
// Ring address: (base + offset) mod DEPTH, both operands below DEPTH.
module blht_addr #(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  logic [AW-1:0] base,
  input  logic [AW-1:0] offset,
  output logic [AW-1:0] phys
);

  logic [AW:0] sum;

  always_comb begin
    sum = {1'b0, base} + {1'b0, offset};
    if (sum >= (AW+1)'(DEPTH)) begin
      sum = sum - (AW+1)'(DEPTH);
    end
    phys = sum[AW-1:0];
  end

endmodule

// ===== design/blht_store.sv =====
// Element RAM: one write, one registered read per cycle.
module blht_store #(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  logic                                clk,
  input  blht_pkg::mem_ctl_t                  ctl,
  input  logic [AW-1:0]                       addr,
  input  logic signed [blht_pkg::VALUE_W-1:0] wdata,
  output logic signed [blht_pkg::VALUE_W-1:0] rdata
);
  import blht_pkg::*;

  logic signed [VALUE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[addr] <= wdata;
    end
    if (ctl.rd_en) begin
      rdata <= mem[addr];
    end
  end

endmodule

// ===== design/blht_seq.sv =====
// Command sequencer: ring head/count, delete compaction, list streaming.
module blht_seq #(
  parameter int DEPTH = 32,
  parameter int AW    = 5,
  parameter int CW    = 6
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic [blht_pkg::MODE_W-1:0]         mode,
  input  logic signed [blht_pkg::VALUE_W-1:0] item_value,
  input  logic [blht_pkg::POS_W-1:0]          position,
  input  logic signed [blht_pkg::VALUE_W-1:0] rdata,
  output logic                                busy,
  output blht_pkg::mem_ctl_t                  ctl,
  output logic [AW-1:0]                       addr,
  output logic signed [blht_pkg::VALUE_W-1:0] wdata,
  output logic                                strobe,
  output logic                                last,
  output logic                                dropped,
  output logic [CW-1:0]                       count
);
  import blht_pkg::*;

  localparam int LW = (CW > POS_W) ? CW : POS_W;

  state_t        state, state_next;
  logic [AW-1:0] head, head_next;
  logic [CW-1:0] count_next;
  logic [CW-1:0] idx, idx_next;
  logic          dropped_next, strobe_next, last_next;
  logic [AW-1:0] offset;
  logic [CW:0]   idx_inc;
  logic          full;
  logic          pos_hit;

  blht_addr #(.DEPTH(DEPTH), .AW(AW)) u_addr (
    .base  (head),
    .offset(offset),
    .phys  (addr)
  );

  assign idx_inc = {1'b0, idx} + (CW+1)'(1);
  assign full    = (count == CW'(DEPTH));
  assign pos_hit = (LW'(position) < LW'(count));
  assign busy    = (state != ST_IDLE);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          if (mode == MODE_DELETE && pos_hit) begin
            state_next = ST_SHIFT_RD;
          end else begin
            state_next = ST_STREAM;
          end
        end
      end
      ST_SHIFT_RD: begin
        if (idx_inc < {1'b0, count}) begin
          state_next = ST_SHIFT_WR;
        end else begin
          state_next = ST_STREAM;
        end
      end
      ST_SHIFT_WR: begin
        state_next = ST_SHIFT_RD;
      end
      ST_STREAM: begin
        if (count == '0 || idx_inc == {1'b0, count}) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    offset       = idx[AW-1:0];
    ctl          = '0;
    wdata        = item_value;
    head_next    = head;
    count_next   = count;
    idx_next     = idx;
    dropped_next = dropped;
    strobe_next  = 1'b0;
    last_next    = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          dropped_next = 1'b0;
          idx_next     = '0;
          case (mode)
            MODE_FRONT: begin
              if (full) begin
                dropped_next = 1'b1;
              end else begin
                offset     = AW'(DEPTH - 1);
                ctl.wr_en  = 1'b1;
                head_next  = addr;
                count_next = count + CW'(1);
              end
            end
            MODE_BACK: begin
              if (full) begin
                dropped_next = 1'b1;
              end else begin
                offset     = count[AW-1:0];
                ctl.wr_en  = 1'b1;
                count_next = count + CW'(1);
              end
            end
            MODE_DELETE: begin
              if (pos_hit) begin
                idx_next = CW'(position);
              end
            end
            default: ;
          endcase
        end
      end
      ST_SHIFT_RD: begin
        offset = idx_inc[AW-1:0];
        if (idx_inc < {1'b0, count}) begin
          ctl.rd_en = 1'b1;
        end else begin
          count_next = count - CW'(1);
          idx_next   = '0;
        end
      end
      ST_SHIFT_WR: begin
        ctl.wr_en = 1'b1;
        wdata     = rdata;
        idx_next  = idx_inc[CW-1:0];
      end
      ST_STREAM: begin
        strobe_next = 1'b1;
        if (count == '0) begin
          last_next = 1'b1;
        end else begin
          ctl.rd_en = 1'b1;
          last_next = (idx_inc == {1'b0, count});
          idx_next  = idx_inc[CW-1:0];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      head    <= '0;
      count   <= '0;
      idx     <= '0;
      dropped <= 1'b0;
      strobe  <= 1'b0;
      last    <= 1'b0;
    end else begin
      state   <= state_next;
      head    <= head_next;
      count   <= count_next;
      idx     <= idx_next;
      dropped <= dropped_next;
      strobe  <= strobe_next;
      last    <= last_next;
    end
  end

endmodule

// ===== design/bounded_list_head_tail_insert_delete.sv =====
// First listing item: accept moves the sequencer to streaming, then the registered strobe
// and RAM read bring it out (insert, no-op, miss delete). No new command is taken while
// busy; busy lasts through delete compaction, which reads then writes each later entry,
// and the listing, streamed one entry a cycle; both share the single RAM port.
// Reset (rst, sync): list becomes empty, sequencer idle; RAM contents are not cleared.
// Items go out on strobe one per cycle, back to back; the receiver cannot stall.
module bounded_list_head_tail_insert_delete #(
  parameter int DEPTH = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic [blht_pkg::MODE_W-1:0]         mode,
  input  logic signed [blht_pkg::VALUE_W-1:0] item_value,
  input  logic [blht_pkg::POS_W-1:0]          position,
  output logic                                strobe,
  output logic signed [blht_pkg::VALUE_W-1:0] element,
  output logic                                list_empty,
  output logic                                last_of_run,
  output logic                                insert_dropped,
  output logic [blht_pkg::COUNT_W-1:0]        entry_count
);
  import blht_pkg::*;

  // Ring index width and entry-count width (count must reach DEPTH).
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  mem_ctl_t                  ctl;
  logic [AW-1:0]             addr;
  logic signed [VALUE_W-1:0] wdata;
  logic signed [VALUE_W-1:0] rdata;
  logic [CW-1:0]             count;

  // Sequencer: owns head pointer and count, drives the single RAM port.
  // Front insert moves head back one slot, back insert writes at head+count,
  // delete pulls every later entry down one slot, then the list is read out.
  blht_seq #(.DEPTH(DEPTH), .AW(AW), .CW(CW)) u_seq (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .mode      (mode),
    .item_value(item_value),
    .position  (position),
    .rdata     (rdata),
    .busy      (busy),
    .ctl       (ctl),
    .addr      (addr),
    .wdata     (wdata),
    .strobe    (strobe),
    .last      (last_of_run),
    .dropped   (insert_dropped),
    .count     (count)
  );

  // Element RAM; its registered read data lines up with strobe.
  blht_store #(.DEPTH(DEPTH), .AW(AW)) u_store (
    .clk  (clk),
    .ctl  (ctl),
    .addr (addr),
    .wdata(wdata),
    .rdata(rdata)
  );

  // Count holds steady through the listing.
  assign list_empty  = (count == '0);
  assign entry_count = COUNT_W'(count);
  // Empty listing shows a zero element, never stale RAM data.
  assign element     = list_empty ? '0 : rdata;

endmodule

// ===== design/blht_checker.sv =====
module blht_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                start,
  input logic                                busy,
  input logic                                strobe,
  input logic signed [blht_pkg::VALUE_W-1:0] element,
  input logic                                list_empty,
  input logic                                last_of_run,
  input logic [blht_pkg::COUNT_W-1:0]        entry_count
);
  `include "bounded_list_head_tail_insert_delete_macros.svh"

  // accepted command always occupies the block
  `BLHT_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "busy low after accept")
  // listing runs without gaps until its final item
  `BLHT_ASSERT_NEXT(a_run_contig, strobe && !last_of_run, strobe, "gap in listing")
  // final item coincides with the block going ready
  `BLHT_ASSERT_NOW(a_last_ready, strobe, last_of_run == !busy, "last/busy mismatch")
  // empty listing is a single zero item with zero count
  `BLHT_ASSERT_NOW(a_empty_item, strobe && list_empty,
    last_of_run && element == '0 && entry_count == '0, "bad empty item")

endmodule

bind bounded_list_head_tail_insert_delete blht_checker u_blht_checker (
  .clk        (clk),
  .rst        (rst),
  .start      (start),
  .busy       (busy),
  .strobe     (strobe),
  .element    (element),
  .list_empty (list_empty),
  .last_of_run(last_of_run),
  .entry_count(entry_count)
);

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
  import blht_pkg::*;

  localparam int LIST_DEPTH = 32;
  // Command code the block decodes as a no-op: the list is only streamed out.
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam logic signed [VALUE_W-1:0] INT_MIN = 32'sh8000_0000;
  localparam logic signed [VALUE_W-1:0] INT_MAX = 32'sh7fff_ffff;
  // Worst quiet stretch: full-list compaction plus the wait for the first item plus a capped
  // sender gap (MAX_GAP). The limit is taken many times over.
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int MAX_GAP = 40;
  localparam int DRAIN_CYCLES = 40;

  logic                      clk;
  logic                      rst = 1'b1;
  logic                      start = 1'b0;
  logic                      busy;
  logic [MODE_W-1:0]         mode = '0;
  logic signed [VALUE_W-1:0] item_value = '0;
  logic [POS_W-1:0]          position = '0;
  logic                      strobe;
  logic signed [VALUE_W-1:0] element;
  logic                      list_empty;
  logic                      last_of_run;
  logic                      insert_dropped;
  logic [COUNT_W-1:0]        entry_count;

  // One entry of the listing the block should stream out.
  typedef struct {
    logic signed [VALUE_W-1:0] element;
    logic                      empty;
    logic                      last;
    logic                      dropped;
    logic [COUNT_W-1:0]        count;
  } listing_item_t;

  // Shadow copy of the list, updated on every accepted command.
  logic signed [VALUE_W-1:0] shadow_list [LIST_DEPTH];
  int                        shadow_len = 0;
  listing_item_t             expected_listing [$];

  int error_count = 0;
  int idle_pct = 0;

  bounded_list_head_tail_insert_delete #(.DEPTH(LIST_DEPTH)) dut (.*);

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Apply one command to the shadow list and queue the full listing it causes.
  task automatic apply_to_shadow_list(input logic [MODE_W-1:0] m,
                                      input logic signed [VALUE_W-1:0] v,
                                      input logic [POS_W-1:0] p);
    listing_item_t row;
    logic          dropped;
    int            i;
    dropped = 1'b0;
    if (m == MODE_FRONT || m == MODE_BACK) begin
      if (shadow_len >= LIST_DEPTH) begin
        dropped = 1'b1;                // full: list untouched, flag it
      end else if (m == MODE_FRONT) begin
        for (i = shadow_len; i > 0; i--) shadow_list[i] = shadow_list[i - 1];
        shadow_list[0] = v;
        shadow_len++;
      end else begin
        shadow_list[shadow_len] = v;
        shadow_len++;
      end
    end else if (m == MODE_DELETE && int'(p) < shadow_len) begin
      // close the gap; positions at or past the count change nothing
      for (i = int'(p); i + 1 < shadow_len; i++) shadow_list[i] = shadow_list[i + 1];
      shadow_len--;
    end
    row.dropped = dropped;
    row.count = COUNT_W'(shadow_len);
    if (shadow_len == 0) begin
      row.element = '0;
      row.empty = 1'b1;
      row.last = 1'b1;
      expected_listing.push_back(row);
    end else begin
      row.empty = 1'b0;
      for (i = 0; i < shadow_len; i++) begin
        row.element = shadow_list[i];
        row.last = (i + 1 == shadow_len);
        expected_listing.push_back(row);
      end
    end
  endtask

  // Drive one command; hold start until the block takes it (start && !busy).
  // A random gap of idle cycles may come first, per idle_pct.
  task automatic send_command(input logic [MODE_W-1:0] m,
                              input logic signed [VALUE_W-1:0] v,
                              input logic [POS_W-1:0] p);
    int gap;
    gap = 0;
    while (idle_pct > 0 && gap < MAX_GAP && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
      gap++;
    end
    start <= 1'b1;
    mode <= m;
    item_value <= v;
    position <= p;
    @(posedge clk);
    while (busy) @(posedge clk);
    // accepted at this edge
    apply_to_shadow_list(m, v, p);
  endtask

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      error_count++;
    end
  endtask

  // Each strobe is one listing item, taken at the edge ending its cycle.
  always @(posedge clk) begin
    listing_item_t want;
    if (!rst && strobe) begin
      if (expected_listing.size() == 0) begin
        $error("unexpected listing item: element %0d count %0d", element, entry_count);
        error_count++;
      end else begin
        want = expected_listing.pop_front();
        // element carries no meaning on an empty listing
        if (!want.empty) check_field("element", want.element, element);
        check_field("list_empty", want.empty, list_empty);
        check_field("last_of_run", want.last, last_of_run);
        check_field("insert_dropped", want.dropped, insert_dropped);
        check_field("entry_count", want.count, entry_count);
      end
    end
  end

  // Ends the run if neither a command nor a listing item moves for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || strobe || (start && !busy)) quiet = 0;
      else quiet++;
    end
    $display("Some tests failed");
    $finish;
  end

  // Empty list: delete at 0 and at the top position, plus the no-op code.
  task automatic test_empty_list();
    send_command(MODE_DELETE, 32'sh1234_5678, 6'd0);
    send_command(MODE_UNUSED, INT_MIN, 6'd63);
    send_command(MODE_DELETE, INT_MAX, 6'd63);
  endtask

  // Both insert ends with value extremes and alternating bit patterns;
  // ignored position field driven to both extremes.
  task automatic test_insert_extremes();
    send_command(MODE_FRONT, INT_MIN, 6'd63);
    send_command(MODE_BACK, INT_MAX, 6'd0);
    send_command(MODE_FRONT, -32'sd1, 6'h2a);
    send_command(MODE_BACK, 32'sd0, 6'h15);
    send_command(MODE_FRONT, 32'sh5555_5555, 6'd63);
    send_command(MODE_BACK, 32'shaaaa_aaaa, 6'd1);
  endtask

  // Six entries now. Deletes past the count, at the count, middle, front,
  // back, then down to an empty listing.
  task automatic test_delete_cases();
    send_command(MODE_DELETE, 32'sd0, 6'd63);
    send_command(MODE_DELETE, 32'sd0, 6'd6);
    send_command(MODE_DELETE, -32'sd1, 6'd2);
    send_command(MODE_DELETE, 32'sd0, 6'd0);
    send_command(MODE_DELETE, 32'sd0, 6'd3);
    send_command(MODE_UNUSED, 32'sh0f0f_0f0f, 6'd0);
    send_command(MODE_DELETE, 32'sd0, 6'd0);
    send_command(MODE_DELETE, 32'sd0, 6'd1);
    send_command(MODE_DELETE, 32'sd0, 6'd0);
    send_command(MODE_DELETE, 32'sd0, 6'd0);
  endtask

  // Random commands with a given insert/delete mix; the rest are no-ops.
  // Deletes mostly hit a live entry, else any position up to 63.
  task automatic test_random_traffic(input int insert_pct, input int delete_pct,
                                     input int n_items);
    logic [MODE_W-1:0]         m;
    logic signed [VALUE_W-1:0] v;
    logic [POS_W-1:0]          p;
    int                        r;
    int                        k;
    for (k = 0; k < n_items; k++) begin
      r = $urandom_range(99);
      if (r < insert_pct) m = $urandom_range(1) ? MODE_BACK : MODE_FRONT;
      else if (r < insert_pct + delete_pct) m = MODE_DELETE;
      else m = MODE_UNUSED;
      case ($urandom_range(7))
        0: v = INT_MIN;
        1: v = INT_MAX;
        2: v = $urandom_range(15) - 8;
        default: v = $urandom;
      endcase
      if (shadow_len > 0 && $urandom_range(3) != 0) begin
        p = POS_W'($urandom_range(shadow_len - 1));
      end else begin
        p = POS_W'($urandom_range(63));
      end
      send_command(m, v, p);
    end
  endtask

  initial begin
    int idle_levels [3] = '{0, 68, 30};
    int ph;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    test_empty_list();
    test_insert_extremes();
    test_delete_cases();

    // Each idling level: fill past capacity (drops, full-list deletes),
    // drain toward empty, then a balanced mix.
    for (ph = 0; ph < 3; ph++) begin
      idle_pct = idle_levels[ph];
      test_random_traffic(88, 10, 50);
      test_random_traffic(15, 80, 40);
      test_random_traffic(45, 45, 30);
    end

    start <= 1'b0;
    while (expected_listing.size() != 0) @(posedge clk);
    // catch any stray items after the last listing
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
